/* hdl/dtsw_pkg.sv */
package dtsw_pkg;

    // Nesting limit and the widths that follow from it.
    localparam int MAX_DEPTH = 64;
    localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);

    // Fixed field widths of the result transaction.
    localparam int WORD_W      = 32;
    localparam int DEPTH_W     = 7;
    localparam int CLASS_W     = 4;
    localparam int ERR_W       = 2;
    localparam int DWL_W       = 30;
    localparam int OUT_TDATA_W = 16;

    // Structure-block tokens.
    localparam logic [WORD_W-1:0] TOK_BEGIN    = 32'd1;
    localparam logic [WORD_W-1:0] TOK_END_NODE = 32'd2;
    localparam logic [WORD_W-1:0] TOK_PROP     = 32'd3;
    localparam logic [WORD_W-1:0] TOK_NOP      = 32'd4;
    localparam logic [WORD_W-1:0] TOK_END      = 32'd9;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TOKEN,
        PH_NAME,
        PH_PLEN,
        PH_POFF,
        PH_PDATA
    } t_phase;

    typedef enum logic [CLASS_W-1:0] {
        CL_BEGIN   = 4'd0,
        CL_NAME    = 4'd1,
        CL_ENDNODE = 4'd2,
        CL_PROP    = 4'd3,
        CL_PLEN    = 4'd4,
        CL_POFF    = 4'd5,
        CL_PDATA   = 4'd6,
        CL_NOP     = 4'd7,
        CL_END     = 4'd8,
        CL_BAD     = 4'd9,
        CL_IDLE    = 4'd10
    } t_class;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_TAG  = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_UNDERRUN = 2'd3
    } t_err;

    typedef struct packed {
        t_phase             phase;
        logic [LEVEL_W-1:0] level;
        logic [DWL_W-1:0]   dwl;
    } t_state;

    typedef struct packed {
        t_class             cls;
        logic [DEPTH_W-1:0] depth;
        logic               done;
        t_err               err;
    } t_result;

endpackage

/* hdl/device_tree_subtree_walker.sv */
// Device tree subtree walker.
// The slave stream carries one big-endian structure-block word per transaction in
// i_s_tdata, with i_s_tuser set on the word that begins a walk (that word must be a
// token). Each accepted word yields exactly one result transaction on the master
// stream: o_m_tuser gives the class of the word, o_m_tdata gives the nesting depth
// after the word and an error code, and o_m_tlast marks the word that completes the
// walk (depth back at zero, an end token, or an error that ends the walk).
// Words that arrive outside a walk give the idle class and are otherwise ignored.
// An accepted word is held in the input register, then processed into the result
// register once that register is empty or drains, and offered on the master side.
// Throughput: one word per cycle while the receiver does not stall. The phase,
// level and data-word count are registered and update from the registered word,
// and that loop sets the rate.
// When the receiver stalls, the result register holds its transaction and the input
// register still takes one more word; then o_s_tready drops until the result moves.
// Reset (synchronous, active low) empties both registers and leaves the walker idle
// at level zero with no data words pending.
module device_tree_subtree_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] word
    input  logic        i_s_tuser,   // [0] start_req
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [6:0] depth, [8:7] error, [15:9] zero
    output logic [3:0]  o_m_tuser,   // [3:0] item_class
    output logic        o_m_tlast    // walk_done
);

    logic                        r_in_valid;
    logic [dtsw_pkg::WORD_W-1:0] r_in_word;
    logic                        r_in_start;
    dtsw_pkg::t_state            r_state;
    dtsw_pkg::t_state            n_state;
    logic                        r_out_valid;
    dtsw_pkg::t_result           r_out;
    dtsw_pkg::t_result           n_out;
    logic                        w_adv;

    // The registered word moves on whenever the result register is empty or drains.
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    dtsw_step u_step (
        .i_word  (r_in_word),
        .i_start (r_in_start),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: dtsw_pkg::PH_IDLE, level: '0, dwl: '0};
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_word  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.cls;
    assign o_m_tlast  = r_out.done;
    assign o_m_tdata  = {{(dtsw_pkg::OUT_TDATA_W - dtsw_pkg::DEPTH_W - dtsw_pkg::ERR_W){1'b0}},
                         r_out.err, r_out.depth};

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.level <= dtsw_pkg::LEVEL_W'(dtsw_pkg::MAX_DEPTH))
        else $error("walker level above its limit");

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out.done) |=> (r_state.phase == dtsw_pkg::PH_IDLE))
        else $error("walk completed but walker did not go idle");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.cls == dtsw_pkg::CL_IDLE) |->
        (r_out.depth == '0 && !r_out.done && r_out.err == dtsw_pkg::ERR_NONE))
        else $error("idle result carries depth, done or error");

    a_bad_tag_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.err == dtsw_pkg::ERR_BAD_TAG) |->
        (r_out.cls == dtsw_pkg::CL_BAD && r_out.done))
        else $error("unknown tag error without bad class and walk end");

    a_underrun_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.err == dtsw_pkg::ERR_UNDERRUN) |->
        (r_out.cls == dtsw_pkg::CL_ENDNODE && r_out.done && r_out.depth == '0))
        else $error("end node at depth zero not reported as walk end");
`endif

endmodule

/* hdl/dtsw_step.sv */
module dtsw_step (
    input  logic [dtsw_pkg::WORD_W-1:0] i_word,
    input  logic                        i_start,
    input  dtsw_pkg::t_state            i_state,
    output dtsw_pkg::t_state            o_state,
    output dtsw_pkg::t_result           o_res
);

    function automatic logic has_zero_byte(input logic [dtsw_pkg::WORD_W-1:0] w);
        return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
               (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
    endfunction

    dtsw_pkg::t_state            cur;
    dtsw_pkg::t_state            nxt;
    dtsw_pkg::t_class            cls;
    dtsw_pkg::t_err              err;
    logic                        done;
    logic                        fin;
    logic [dtsw_pkg::WORD_W-1:0] len_sum;
    logic [dtsw_pkg::DWL_W-1:0]  dwl_dec;

    always_comb begin
        cur = i_state;
        if (i_start) begin
            cur.phase = dtsw_pkg::PH_TOKEN;
            cur.level = '0;
            cur.dwl   = '0;
        end
        nxt     = cur;
        cls     = dtsw_pkg::CL_IDLE;
        err     = dtsw_pkg::ERR_NONE;
        done    = 1'b0;
        fin     = 1'b0;
        // The length is rounded up in 32 bits, so a sum that wraps gives a count of zero.
        len_sum = i_word + 32'd3;
        dwl_dec = (cur.dwl != '0) ? cur.dwl - 1'b1 : cur.dwl;

        unique case (cur.phase)
            dtsw_pkg::PH_TOKEN: begin
                unique case (i_word)
                    dtsw_pkg::TOK_BEGIN: begin
                        cls       = dtsw_pkg::CL_BEGIN;
                        nxt.phase = dtsw_pkg::PH_NAME;
                        if (cur.level >= dtsw_pkg::LEVEL_W'(dtsw_pkg::MAX_DEPTH)) begin
                            nxt.level = dtsw_pkg::LEVEL_W'(dtsw_pkg::MAX_DEPTH);
                            err       = dtsw_pkg::ERR_OVERFLOW;
                        end else begin
                            nxt.level = cur.level + 1'b1;
                        end
                    end
                    dtsw_pkg::TOK_END_NODE: begin
                        cls = dtsw_pkg::CL_ENDNODE;
                        if (cur.level == '0) begin
                            err       = dtsw_pkg::ERR_UNDERRUN;
                            done      = 1'b1;
                            nxt.phase = dtsw_pkg::PH_IDLE;
                        end else begin
                            nxt.level = cur.level - 1'b1;
                            fin       = 1'b1;
                        end
                    end
                    dtsw_pkg::TOK_PROP: begin
                        cls       = dtsw_pkg::CL_PROP;
                        nxt.phase = dtsw_pkg::PH_PLEN;
                    end
                    dtsw_pkg::TOK_NOP: begin
                        cls = dtsw_pkg::CL_NOP;
                        fin = 1'b1;
                    end
                    dtsw_pkg::TOK_END: begin
                        cls       = dtsw_pkg::CL_END;
                        done      = 1'b1;
                        nxt.phase = dtsw_pkg::PH_IDLE;
                    end
                    default: begin
                        cls       = dtsw_pkg::CL_BAD;
                        err       = dtsw_pkg::ERR_BAD_TAG;
                        done      = 1'b1;
                        nxt.phase = dtsw_pkg::PH_IDLE;
                    end
                endcase
            end
            dtsw_pkg::PH_NAME: begin
                cls = dtsw_pkg::CL_NAME;
                fin = has_zero_byte(i_word);
            end
            dtsw_pkg::PH_PLEN: begin
                cls       = dtsw_pkg::CL_PLEN;
                nxt.dwl   = len_sum[dtsw_pkg::WORD_W-1:2];
                nxt.phase = dtsw_pkg::PH_POFF;
            end
            dtsw_pkg::PH_POFF: begin
                cls = dtsw_pkg::CL_POFF;
                if (cur.dwl == '0) begin
                    fin = 1'b1;
                end else begin
                    nxt.phase = dtsw_pkg::PH_PDATA;
                end
            end
            dtsw_pkg::PH_PDATA: begin
                cls     = dtsw_pkg::CL_PDATA;
                nxt.dwl = dwl_dec;
                fin     = (dwl_dec == '0);
            end
            default: begin
                nxt.phase = dtsw_pkg::PH_IDLE;
            end
        endcase

        // A finished item closes the walk once the level is back at zero.
        if (fin) begin
            done      = (nxt.level == '0);
            nxt.phase = done ? dtsw_pkg::PH_IDLE : dtsw_pkg::PH_TOKEN;
        end

        o_state       = nxt;
        o_res.cls     = cls;
        o_res.depth   = (cls == dtsw_pkg::CL_IDLE) ? '0 : dtsw_pkg::DEPTH_W'(nxt.level);
        o_res.done    = done;
        o_res.err     = err;
    end

endmodule

/* dv/device_tree_subtree_walker_test.sv */
`timescale 1ns / 100ps

// Scoreboard for the subtree walker. It keeps its own copy of the walk state,
// works out the result of every accepted word, and compares each result that
// leaves the block with the oldest outstanding expectation.
class subtree_tracker;
    dtsw_pkg::t_phase                phase;
    int unsigned                     lvl;
    logic [dtsw_pkg::DWL_W-1:0]      words_to_skip;
    dtsw_pkg::t_result               pending_results[$];
    int                              fails;

    function new();
        phase         = dtsw_pkg::PH_IDLE;
        lvl           = 0;
        words_to_skip = '0;
        fails         = 0;
    endfunction

    // A token has been fully consumed: the walk completes once back at level zero.
    function bit close_item();
        if (lvl == 0) begin
            phase = dtsw_pkg::PH_IDLE;
            return 1'b1;
        end
        phase = dtsw_pkg::PH_TOKEN;
        return 1'b0;
    endfunction

    // Predicts the result of one accepted word and queues it. Returns its class.
    function dtsw_pkg::t_class note_word(logic [31:0] w, logic start);
        dtsw_pkg::t_result r;
        logic [32:0]       rounded;
        bit                zero_byte;

        r.cls  = dtsw_pkg::CL_IDLE;
        r.err  = dtsw_pkg::ERR_NONE;
        r.done = 1'b0;
        if (start) begin
            phase         = dtsw_pkg::PH_TOKEN;
            lvl           = 0;
            words_to_skip = '0;
        end
        case (phase)
            dtsw_pkg::PH_TOKEN: begin
                case (w)
                    dtsw_pkg::TOK_BEGIN: begin
                        r.cls = dtsw_pkg::CL_BEGIN;
                        if (lvl >= dtsw_pkg::MAX_DEPTH) begin
                            lvl   = dtsw_pkg::MAX_DEPTH;
                            r.err = dtsw_pkg::ERR_OVERFLOW;
                        end else begin
                            lvl++;
                        end
                        phase = dtsw_pkg::PH_NAME;
                    end
                    dtsw_pkg::TOK_END_NODE: begin
                        r.cls = dtsw_pkg::CL_ENDNODE;
                        if (lvl == 0) begin
                            r.err  = dtsw_pkg::ERR_UNDERRUN;
                            r.done = 1'b1;
                            phase  = dtsw_pkg::PH_IDLE;
                        end else begin
                            lvl--;
                            r.done = close_item();
                        end
                    end
                    dtsw_pkg::TOK_PROP: begin
                        r.cls = dtsw_pkg::CL_PROP;
                        phase = dtsw_pkg::PH_PLEN;
                    end
                    dtsw_pkg::TOK_NOP: begin
                        r.cls  = dtsw_pkg::CL_NOP;
                        r.done = close_item();
                    end
                    dtsw_pkg::TOK_END: begin
                        r.cls  = dtsw_pkg::CL_END;
                        r.done = 1'b1;
                        phase  = dtsw_pkg::PH_IDLE;
                    end
                    default: begin
                        r.cls  = dtsw_pkg::CL_BAD;
                        r.err  = dtsw_pkg::ERR_BAD_TAG;
                        r.done = 1'b1;
                        phase  = dtsw_pkg::PH_IDLE;
                    end
                endcase
            end
            dtsw_pkg::PH_NAME: begin
                r.cls = dtsw_pkg::CL_NAME;
                zero_byte = (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
                            (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
                if (zero_byte) begin
                    r.done = close_item();
                end
            end
            dtsw_pkg::PH_PLEN: begin
                r.cls = dtsw_pkg::CL_PLEN;
                // Round the byte count up to whole words within 32 bits; a carry
                // out of bit 31 is lost, so the top three lengths skip nothing.
                rounded       = {1'b0, w} + 33'd3;
                words_to_skip = rounded[31:2];
                phase         = dtsw_pkg::PH_POFF;
            end
            dtsw_pkg::PH_POFF: begin
                r.cls = dtsw_pkg::CL_POFF;
                if (words_to_skip == '0) begin
                    r.done = close_item();
                end else begin
                    phase = dtsw_pkg::PH_PDATA;
                end
            end
            dtsw_pkg::PH_PDATA: begin
                r.cls = dtsw_pkg::CL_PDATA;
                if (words_to_skip != '0) begin
                    words_to_skip--;
                end
                if (words_to_skip == '0) begin
                    r.done = close_item();
                end
            end
            default: begin
                phase = dtsw_pkg::PH_IDLE;
                r.cls = dtsw_pkg::CL_IDLE;
            end
        endcase
        r.depth = (r.cls == dtsw_pkg::CL_IDLE) ? '0 : dtsw_pkg::DEPTH_W'(lvl);
        pending_results.push_back(r);
        return r.cls;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Compares one result transaction, field by field, with the oldest expectation.
    function void check_result(logic [3:0] cls_bits, logic [15:0] data, logic last);
        dtsw_pkg::t_result want;

        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: class %0d depth %0d error %0d last %0b",
                     $time, cls_bits, data[6:0], data[8:7], last);
            fails++;
            return;
        end
        want = pending_results.pop_front();
        if (cls_bits !== want.cls) begin
            $display("%0t: item_class mismatch: expected %0d, actual %0d",
                     $time, want.cls, cls_bits);
            fails++;
        end
        if (data[6:0] !== want.depth) begin
            $display("%0t: depth mismatch: expected %0d, actual %0d",
                     $time, want.depth, data[6:0]);
            fails++;
        end
        if (data[8:7] !== want.err) begin
            $display("%0t: error mismatch: expected %0d, actual %0d",
                     $time, want.err, data[8:7]);
            fails++;
        end
        if (last !== want.done) begin
            $display("%0t: walk_done mismatch: expected %0b, actual %0b",
                     $time, want.done, last);
            fails++;
        end
        if (data[15:9] !== 7'd0) begin
            $display("%0t: tdata padding mismatch: expected 0, actual %0h",
                     $time, data[15:9]);
            fails++;
        end
    endfunction
endclass

module device_tree_subtree_walker_test;

    // Receiver stall patterns; each one holds for a random stretch of cycles.
    localparam int RX_OPEN    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_SPARSE  = 2;
    localparam int RX_BLOCKS  = 3;

    // Number of walk words (words the block does not ignore), directed ones included, after which random walks stop.
    localparam int WALK_WORDS = 1900;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;    // [31:0] word
    logic        i_s_tuser  = 1'b0;  // [0] start_req
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;          // [6:0] depth, [8:7] error, [15:9] zero
    logic [3:0]  o_m_tuser;          // [3:0] item_class
    logic        o_m_tlast;          // walk_done

    subtree_tracker tracker;

    // Sender bookkeeping: words left in the current burst, the count of words
    // that took part in a walk, and whether the next word opens a walk.
    int burst_left;
    int walk_words;
    bit start_next;

    // Receiver bookkeeping.
    int rx_mode;
    int rx_mode_left;
    int rx_stall_left;

    device_tree_subtree_walker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 12 ns clock, low half first.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver changes its stall pattern every so often, so that back
    // pressure lands on every phase of a walk. One pattern never stalls, one
    // flips a coin, one accepts rarely and one stalls in long blocks.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_OPEN, RX_BLOCKS);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_OPEN: begin
                i_m_tready <= 1'b1;
            end
            RX_COIN: begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                i_m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (rx_stall_left > 0) begin
                    i_m_tready <= 1'b0;
                    rx_stall_left--;
                end else begin
                    i_m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) begin
                        rx_stall_left = $urandom_range(1, 12);
                    end
                end
            end
        endcase
    end

    // Every result transaction is checked at the edge where it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_result(o_m_tuser, o_m_tdata, o_m_tlast);
        end
    end

    // Offers one word and holds it until the block takes it. Called at a falling
    // edge and returns at a falling edge. Before a new burst the sender may drop
    // tvalid; bursts are long enough to give stretches with no gaps at all.
    task automatic send_word(input logic [31:0] w, input logic start);
        int               gap;
        dtsw_pkg::t_class cls;

        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        i_s_tuser  <= start;
        do @(posedge i_clk); while (!o_s_tready);
        cls = tracker.note_word(w, start);
        if (cls != dtsw_pkg::CL_IDLE) begin
            walk_words++;
        end
        @(negedge i_clk);
    endtask

    // Sends a word of a walk; the first word after a walk is opened carries start.
    task automatic put(input logic [31:0] w);
        send_word(w, start_next);
        start_next = 1'b0;
    endtask

    // Name word without a zero byte, so the name goes on.
    function automatic logic [31:0] name_body();
        return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endfunction

    // Name word with at least one zero byte, which ends the name.
    function automatic logic [31:0] name_tail();
        logic [31:0] w;
        int          pos;

        w   = $urandom;
        pos = $urandom_range(0, 3);
        w[pos*8 +: 8] = 8'h00;
        if ($urandom_range(0, 7) == 0) begin
            w = '0;
        end
        return w;
    endfunction

    // Property length in bytes, mostly a few words.
    function automatic logic [31:0] rand_prop_bytes();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64) : $urandom_range(0, 20);
    endfunction

    task automatic send_name();
        repeat ($urandom_range(0, 2)) put(name_body());
        put(name_tail());
    endtask

    task automatic send_prop(input logic [31:0] len);
        put(dtsw_pkg::TOK_PROP);
        put(len);
        put($urandom);
        repeat ((len + 3) / 4) put($urandom);
    endtask

    // A well-formed subtree with random content: nodes, properties and no-ops
    // nested up to max_nest, closing down once the step budget is spent.
    task automatic send_subtree(input int max_nest, input int budget);
        int open;
        int steps;
        int pick;

        start_next = 1'b1;
        put(dtsw_pkg::TOK_BEGIN);
        send_name();
        open  = 1;
        steps = 0;
        while (open > 0) begin
            pick = $urandom_range(0, 9);
            steps++;
            if (steps > budget) begin
                pick = 9;
            end
            if (pick <= 2 && open < max_nest) begin
                put(dtsw_pkg::TOK_BEGIN);
                send_name();
                open++;
            end else if (pick <= 5) begin
                send_prop(rand_prop_bytes());
            end else if (pick == 6) begin
                put(dtsw_pkg::TOK_NOP);
            end else begin
                put(dtsw_pkg::TOK_END_NODE);
                open--;
            end
        end
    endtask

    // Nests past the depth limit so that level saturates, then unwinds to zero.
    task automatic send_deep_walk();
        start_next = 1'b1;
        repeat (dtsw_pkg::MAX_DEPTH + 2) begin
            put(dtsw_pkg::TOK_BEGIN);
            put(name_tail());
        end
        repeat (dtsw_pkg::MAX_DEPTH) put(dtsw_pkg::TOK_END_NODE);
    endtask

    // A walk that goes wrong part way: a bad tag, an early end token, a huge
    // property, or a walk simply abandoned by the next start.
    task automatic send_broken_walk();
        start_next = 1'b1;
        put(dtsw_pkg::TOK_BEGIN);
        send_name();
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
                send_prop(rand_prop_bytes());
            end else begin
                put(dtsw_pkg::TOK_NOP);
            end
        end
        case ($urandom_range(0, 5))
            0: put($urandom);
            1: put(dtsw_pkg::TOK_END);
            2: ;
            3: begin
                put(dtsw_pkg::TOK_PROP);
                case ($urandom_range(0, 2))
                    0: put($urandom);
                    1: put(32'hFFFF_FFFC);
                    default: put(32'hFFFF_FFFF);
                endcase
                put($urandom);
                repeat ($urandom_range(0, 4)) put($urandom);
            end
            4: begin
                put(dtsw_pkg::TOK_PROP);
                put($urandom_range(1, 12));
            end
            default: begin
                put(dtsw_pkg::TOK_BEGIN);
                repeat ($urandom_range(1, 3)) put(name_body());
            end
        endcase
    endtask

    // A walk that starts on something other than a begin token.
    task automatic send_short_walk();
        start_next = 1'b1;
        case ($urandom_range(0, 4))
            0: put(dtsw_pkg::TOK_NOP);
            1: put(dtsw_pkg::TOK_END);
            2: put(dtsw_pkg::TOK_END_NODE);
            3: put($urandom);
            default: send_prop(rand_prop_bytes());
        endcase
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending() != 0);
        burst_left = 0;
    endtask

    initial begin
        int  pick;
        bit  drained;

        tracker       = new();
        burst_left    = 0;
        walk_words    = 0;
        start_next    = 1'b0;
        rx_mode       = RX_OPEN;
        rx_mode_left  = 0;
        rx_stall_left = 0;
        drained       = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words. Words outside a walk are ignored.
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        // One node with two properties and a no-op. The first property length
        // rounds past 32 bits, so no data follows its name offset.
        start_next = 1'b1;
        put(dtsw_pkg::TOK_BEGIN);
        put(32'h6E6F_6465);
        put(32'h2D31_0000);
        put(dtsw_pkg::TOK_PROP);
        put(32'hFFFF_FFFD);
        put(32'hFFFF_FFFF);
        put(dtsw_pkg::TOK_PROP);
        put(32'd5);
        put(32'h0000_0000);
        put(32'hFFFF_FFFF);
        put(32'h0000_0000);
        put(dtsw_pkg::TOK_NOP);
        put(dtsw_pkg::TOK_END_NODE);
        // End node at depth zero, a bad tag, the end token and a lone no-op.
        send_word(dtsw_pkg::TOK_END_NODE, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(dtsw_pkg::TOK_END, 1'b1);
        send_word(dtsw_pkg::TOK_NOP, 1'b1);
        // A zero-length property completes a walk on its name offset.
        send_word(dtsw_pkg::TOK_PROP, 1'b1);
        send_word(32'd0, 1'b0);
        send_word(32'd7, 1'b0);
        // A start in the middle of a walk abandons it.
        send_word(dtsw_pkg::TOK_BEGIN, 1'b1);
        send_word(dtsw_pkg::TOK_BEGIN, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(dtsw_pkg::TOK_END_NODE, 1'b0);

        // Random walks, mostly well formed, with one deep walk up front.
        send_deep_walk();
        while (walk_words < WALK_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                send_subtree($urandom_range(1, 6), $urandom_range(4, 30));
            end else if (pick < 73) begin
                send_broken_walk();
            end else if (pick < 84) begin
                send_short_walk();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) send_word($urandom, ($urandom_range(0, 3) == 0));
            end else if (pick < 91) begin
                send_deep_walk();
            end else begin
                repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
            end
            if (!drained && walk_words > WALK_WORDS / 2) begin
                drain();
                drained = 1'b1;
            end
        end

        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
